// ===== hw/rtl/q4k_superblock_dot_product_top_defines.svh =====
// ----------------------------------------------------------------------------
// q4k superblock dot product: assertion macros
// Shared property macros clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef Q4K_SUPERBLOCK_DOT_PRODUCT_TOP_DEFINES_SVH
`define Q4K_SUPERBLOCK_DOT_PRODUCT_TOP_DEFINES_SVH

// same-cycle implication
`define Q4K_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define Q4K_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/q4k_pkg.sv =====
// ----------------------------------------------------------------------------
// q4k_pkg
// Types, constants and fp32 arithmetic helpers for the q4k dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package q4k_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [31:0] QNAN        = 32'h7FC0_0000;
  localparam logic [7:0]  MASK_LO4    = 8'h0f;
  localparam logic [7:0]  MASK_LO6    = 8'h3f;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_elem;
    logic        last;
    logic [2:0]  grp;
    logic [3:0]  nib;
    logic [31:0] act;
    logic [15:0] delta;
    logic [15:0] min_delta;
    logic [95:0] scales;
  } item_t;

  typedef struct packed {
    logic       full;
    logic [7:0] count;
  } front_stat_t;

  typedef struct packed {
    logic emit;
    logic busy;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_POP,
    ST_MUL_D,
    ST_MUL_M,
    ST_MUL_W,
    ST_SUB,
    ST_PROD,
    ST_ACC
  } back_state_e;

  // round to nearest even and pack; sig has its msb at bit 47
  function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                             input logic [47:0] sig);
    logic [47:0] sh;
    logic        sticky;
    logic [11:0] rs;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic        rnd;
    logic [7:0]  ee;
    logic [30:0] r;
    sh     = sig;
    sticky = 1'b0;
    ee     = e[7:0];
    if (e >= 12'sd255) return {s, 8'hff, 23'd0};
    if (e <= 12'sd0) begin
      rs = 12'(12'sd1 - e);
      if (rs >= 12'd48) begin
        sticky = |sig;
        sh     = '0;
      end else begin
        sticky = |(sig & ~({48{1'b1}} << rs));
        sh     = sig >> rs;
      end
      ee = '0;
    end
    m   = sh[47:24];
    g   = sh[23];
    st  = (|sh[22:0]) | sticky;
    rnd = g & (st | m[0]);
    r   = {ee, m[22:0]} + 31'(rnd);
    return {s, r};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic        s;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic        zero_a;
    logic        zero_b;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [11:0] e;
    ea     = a[30:23];
    eb     = b[30:23];
    s      = a[31] ^ b[31];
    nan_a  = (ea == 8'hff) && (a[22:0] != '0);
    nan_b  = (eb == 8'hff) && (b[22:0] != '0);
    inf_a  = (ea == 8'hff) && (a[22:0] == '0);
    inf_b  = (eb == 8'hff) && (b[22:0] == '0);
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    if (nan_a || nan_b) return QNAN;
    if (inf_a || inf_b) return (zero_a || zero_b) ? QNAN : {s, 8'hff, 23'd0};
    if (zero_a || zero_b) return {s, 31'd0};
    ma = {(ea != '0), a[22:0]};
    mb = {(eb != '0), b[22:0]};
    if (ea == '0) ea = 8'd1;
    if (eb == '0) eb = 8'd1;
    p  = ma * mb;
    lz = '0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    e = 12'(ea) + 12'(eb) - 12'sd126 - 12'(lz);
    return round_pack(s, e, p << lz);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [48:0] av;
    logic [48:0] bf;
    logic [48:0] bv;
    logic [48:0] sum;
    logic [48:0] pn;
    logic [47:0] sig;
    logic [5:0]  lz;
    logic signed [11:0] e;
    if ((a[30:23] == 8'hff) && (a[22:0] != '0)) return QNAN;
    if ((b[30:23] == 8'hff) && (b[22:0] != '0)) return QNAN;
    if ((a[30:23] == 8'hff) && (b[30:23] == 8'hff) && (a[31] != b[31])) return QNAN;
    if (a[30:23] == 8'hff) return a;
    if (b[30:23] == 8'hff) return b;
    if ((a[30:0] == '0) && (b[30:0] == '0)) return {a[31] & b[31], 31'd0};
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    av = {1'b0, (x[30:23] != '0), x[22:0], 24'd0};
    bf = {1'b0, (y[30:23] != '0), y[22:0], 24'd0};
    if (d >= 8'd49) begin
      bv = 49'(|bf);
    end else begin
      bv = (bf >> d) | 49'(|(bf & ~({49{1'b1}} << d)));
    end
    sum = (x[31] == y[31]) ? av + bv : av - bv;
    if (sum == '0) return 32'd0;
    lz = '0;
    for (int i = 0; i < 49; i++) begin
      if (sum[i]) lz = 6'(48 - i);
    end
    pn  = sum << lz;
    sig = pn[48:1] | 48'(pn[0]);
    e   = 12'(ex) + 12'sd1 - 12'(lz);
    return round_pack(x[31], e, sig);
  endfunction

  // small unsigned integer to fp32, exact
  function automatic logic [31:0] int_to_fp(input logic [5:0] v);
    logic [4:0]  p;
    logic [23:0] t;
    p = '0;
    for (int i = 0; i < 6; i++) begin
      if (v[i]) p = 5'(i);
    end
    t = 24'(v) << (5'd23 - p);
    return (v == '0) ? 32'd0 : {1'b0, 8'(8'd127 + 8'(p)), t[22:0]};
  endfunction

  // fp16 to fp32, exact
  function automatic logic [31:0] half_to_fp(input logic [15:0] h);
    logic [4:0]  p;
    logic [23:0] t;
    p = '0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) p = 5'(i);
    end
    t = 24'(h[9:0]) << (5'd23 - p);
    if (h[14:10] == 5'd0) begin
      return (h[9:0] == '0) ? {h[15], 31'd0} : {h[15], 8'(8'd103 + 8'(p)), t[22:0]};
    end
    if (h[14:10] == 5'd31) return {h[15], 8'hff, h[9:0], 13'd0};
    return {h[15], 8'(8'(h[14:10]) + 8'd112), h[9:0], 13'd0};
  endfunction

  // 6-bit scale and min of a sub-group, returned as {min, scale}
  function automatic logic [11:0] unpack_sc_mn(input logic [95:0] q, input logic [2:0] j);
    logic [7:0] b [12];
    logic [3:0] jj;
    logic [5:0] sc;
    logic [5:0] mn;
    for (int k = 0; k < 12; k++) b[k] = q[8*k +: 8];
    jj = {1'b0, j};
    if (j[2] == 1'b0) begin
      sc = 6'(b[jj] & MASK_LO6);
      mn = 6'(b[jj + 4'd4] & MASK_LO6);
    end else begin
      sc = {b[jj - 4'd4][7:6], 4'(b[jj + 4'd4] & MASK_LO4)};
      mn = {b[jj][7:6], b[jj + 4'd4][7:4]};
    end
    return {mn, sc};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/q4k_front.sv =====
// ----------------------------------------------------------------------------
// q4k_front
// Accepts stream words, classifies header and element items, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module q4k_front #(
  parameter int unsigned Depth = q4k_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [175:0]     in_data_i,
  input  wire logic             in_user_i,
  input  wire logic             in_last_i,
  output      logic             item_valid_o,
  output      q4k_pkg::item_t   item_o,
  input  wire logic             item_pop_i,
  output      q4k_pkg::front_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q4k_pkg::item_t        mem_q [Depth];
  q4k_pkg::item_t        item_new;
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  push;
  logic                  pop;
  logic [7:0]            idx;

  assign idx = in_data_i[135:128];

  always_comb begin
    item_new           = '0;
    item_new.is_elem   = (in_user_i == q4k_pkg::OP_ELEMENT);
    item_new.last      = in_last_i;
    item_new.grp       = idx[7:5];
    // odd sub-groups take the high nibble
    item_new.nib       = idx[5] ? in_data_i[143:140] : in_data_i[139:136];
    item_new.act       = in_data_i[175:144];
    item_new.delta     = in_data_i[15:0];
    item_new.min_delta = in_data_i[31:16];
    item_new.scales    = {in_data_i[127:80], in_data_i[79:32]};
  end

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_new;
  end

  assign stat_o.full  = !in_ready_o;
  assign stat_o.count = 8'(cnt_q);

endmodule

`default_nettype wire

// ===== hw/rtl/q4k_back.sv =====
// ----------------------------------------------------------------------------
// q4k_back
// Sequences the dequantize, multiply and accumulate steps one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module q4k_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire q4k_pkg::item_t   item_i,
  output      logic             item_pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [31:0]      out_data_o,
  output      q4k_pkg::back_stat_t stat_o
);

  q4k_pkg::back_state_e state_q, state_d;

  logic [15:0] delta_q, delta_d;
  logic [15:0] min_delta_q, min_delta_d;
  logic [95:0] scales_q, scales_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] t_q, t_d;
  logic [31:0] m_q, m_d;
  logic [2:0]  grp_q, grp_d;
  logic [3:0]  nib_q, nib_d;
  logic [31:0] act_q, act_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic [11:0] scmn;
  logic [31:0] sum;
  logic        emit;

  assign scmn = q4k_pkg::unpack_sc_mn(scales_q, grp_q);
  assign sum  = q4k_pkg::fp_add(acc_q, t_q);

  always_comb begin
    state_d     = state_q;
    delta_d     = delta_q;
    min_delta_d = min_delta_q;
    scales_d    = scales_q;
    acc_d       = acc_q;
    t_d         = t_q;
    m_d         = m_q;
    grp_d       = grp_q;
    nib_d       = nib_q;
    act_d       = act_q;
    last_d      = last_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    item_pop_o  = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      q4k_pkg::ST_POP: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.is_elem) begin
            grp_d   = item_i.grp;
            nib_d   = item_i.nib;
            act_d   = item_i.act;
            last_d  = item_i.last;
            state_d = q4k_pkg::ST_MUL_D;
          end else begin
            delta_d     = item_i.delta;
            min_delta_d = item_i.min_delta;
            scales_d    = item_i.scales;
          end
        end
      end
      q4k_pkg::ST_MUL_D: begin
        t_d = q4k_pkg::fp_mul(q4k_pkg::half_to_fp(delta_q), q4k_pkg::int_to_fp(scmn[5:0]));
        state_d = q4k_pkg::ST_MUL_M;
      end
      q4k_pkg::ST_MUL_M: begin
        m_d = q4k_pkg::fp_mul(q4k_pkg::half_to_fp(min_delta_q),
                              q4k_pkg::int_to_fp(scmn[11:6]));
        state_d = q4k_pkg::ST_MUL_W;
      end
      q4k_pkg::ST_MUL_W: begin
        t_d     = q4k_pkg::fp_mul(t_q, q4k_pkg::int_to_fp({2'b00, nib_q}));
        state_d = q4k_pkg::ST_SUB;
      end
      q4k_pkg::ST_SUB: begin
        t_d     = q4k_pkg::fp_add(t_q, {~m_q[31], m_q[30:0]});
        state_d = q4k_pkg::ST_PROD;
      end
      q4k_pkg::ST_PROD: begin
        t_d     = q4k_pkg::fp_mul(t_q, act_q);
        state_d = q4k_pkg::ST_ACC;
      end
      q4k_pkg::ST_ACC: begin
        if (!last_q) begin
          acc_d   = sum;
          state_d = q4k_pkg::ST_POP;
        end else if (!out_valid_q || out_ready_i) begin
          emit        = 1'b1;
          // any nan leaves as the canonical quiet nan
          out_data_d  = ((sum[30:23] == 8'hff) && (sum[22:0] != '0)) ? q4k_pkg::QNAN : sum;
          out_valid_d = 1'b1;
          acc_d       = 32'd0;
          state_d     = q4k_pkg::ST_POP;
        end
      end
      default: state_d = q4k_pkg::ST_POP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= q4k_pkg::ST_POP;
      delta_q     <= '0;
      min_delta_q <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      delta_q     <= delta_d;
      min_delta_q <= min_delta_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scales_q   <= scales_d;
    t_q        <= t_d;
    m_q        <= m_d;
    grp_q      <= grp_d;
    nib_q      <= nib_d;
    act_q      <= act_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign stat_o.emit = emit;
  assign stat_o.busy = (state_q != q4k_pkg::ST_POP);

endmodule

`default_nettype wire

// ===== hw/rtl/q4k_superblock_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// q4k_superblock_dot_product_top
// Dot product of 4-bit k-quantized weights with fp32 activations.
// ----------------------------------------------------------------------------
// A header word (tuser = 0) loads the superblock scale, min scale and packed
// scale bytes in the execute stage. An element word (tuser = 1) passes there
// through the pop, dequantize, weight and accumulate states: the steps run
// one at a time through fp32 multiply and add helpers, one operation per
// cycle unless the accumulate waits on a held result, and the fp32 accumulate closes each element. A queue
// of QueueDepth words sits in front, so input is taken while execution runs,
// and the result register lets the next item start while a sum waits on
// m_axis. An element with tlast set emits the sum (any nan as 0x7fc00000)
// and clears the accumulator; tlast is ignored on headers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "q4k_superblock_dot_product_top_defines.svh"

module q4k_superblock_dot_product_top #(
  parameter int unsigned QueueDepth = q4k_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // delta_bits, min_delta_bits, scale_bytes_lo, scale_bytes_hi,
  // element_index, quant_byte, activation_bits
  input  wire logic [175:0] s_axis_tdata,
  // opcode
  input  wire logic         s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // dot_bits
  output      logic [31:0]  m_axis_tdata
);

  logic                  item_valid;
  logic                  item_pop;
  q4k_pkg::item_t        item;
  q4k_pkg::front_stat_t  front_stat;
  q4k_pkg::back_stat_t   back_stat;

  q4k_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop),
    .stat_o      (front_stat)
  );

  q4k_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .stat_o      (back_stat)
  );

  `Q4K_ASSERT_IMPL(a_queue_bound, 1'b1, front_stat.count <= 8'(QueueDepth), "queue overrun")
  `Q4K_ASSERT_IMPL(a_pop_when_idle, item_pop, item_valid && !back_stat.busy, "bad pop")
  `Q4K_ASSERT_NEXT(a_emit_shows, back_stat.emit, m_axis_tvalid, "emitted sum not shown")
  `Q4K_ASSERT_IMPL(a_rise_from_emit, $rose(m_axis_tvalid), $past(back_stat.emit),
                   "result without emit")

endmodule

`default_nettype wire
